### rtl/acd_pkg.sv
package acd_pkg;

  // Divider datapath widths: long operations cover the full product of the
  // source clock and the scale factor, short ones cover everything else.
  localparam int DIV_DW    = 60;
  localparam int DIV_VW    = 41;
  localparam int DIV_SHORT = 36;

  localparam int PRIME_COUNT = 46;
  localparam int MULT_LIMIT  = 256;

  localparam logic [28:0] CPU_RESET_HZ = 29'd96000000;
  localparam logic [29:0] FREF_STEP    = 30'd1000000;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_MULT = 2'd1;
  localparam logic [1:0] STAT_UNFACT  = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;

  // Device kinds.
  localparam logic [1:0] KIND_GENERIC = 2'd0;
  localparam logic [1:0] KIND_CODEC   = 2'd1;
  localparam logic [1:0] KIND_BOARD   = 2'd2;
  localparam logic [1:0] KIND_CONV    = 2'd3;

  // Register index of the source clock frequency.
  localparam logic REG_CPU_CLOCK = 1'b0;

  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FREF_GO,
    ST_FREF_WAIT,
    ST_S0_MUL,
    ST_DIVR_GO,
    ST_DIVR_WAIT,
    ST_FIND,
    ST_M2_MUL,
    ST_M2_GO,
    ST_M2_WAIT,
    ST_M3_GO,
    ST_M3_WAIT,
    ST_GQ_MUL,
    ST_GQ_GO,
    ST_GQ_WAIT,
    ST_TP_GO,
    ST_TP_WAIT,
    ST_TP_FIN,
    ST_CHECK,
    ST_DONE
  } state_t;

  localparam logic [8:0] PRIMES [64] = '{
    9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
    9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
    9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
    9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
    9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
    9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
    9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
    9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
  };

endpackage

### rtl/audio_clock_divider_solver.sv
// Solves one clock divider request at a time on a shared restoring divider.
// Codec, board and converter kinds: reference steps, then 2 or 3 divisions and a multiplier search.
// Generic kind: 2 divisions around a multiplier search, then one division per prime trial.
// Throughput is one item per solve; the next item is taken once the result is registered.
// Synchronous active-low reset clears control state and loads a 96 MHz source clock.
module audio_clock_divider_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_device_kind,
  input  logic [5:0]  in_word_bits,
  input  logic [18:0] in_sample_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_mclk_multiplier_code,
  output logic [11:0] out_mclk_divider_code,
  output logic [7:0]  out_bit_clock_divider_code,
  output logic [5:0]  out_word_bits_used
);
  import acd_pkg::*;

  state_t state_r, state_nxt;

  logic [28:0] cpu_r;
  logic [1:0]  kind_r;
  logic [5:0]  nb_r;
  logic [18:0] fs_r;
  logic [1:0]  nov_sh_r;
  logic [29:0] fref_r;
  logic [29:0] scl_r;
  logic [58:0] s0_r;
  logic [40:0] rate_r;
  logic [40:0] r_r;
  logic [40:0] acc_r;
  logic [7:0]  m_r;
  logic [7:0]  m1_r;
  logic [30:0] q0_r;
  logic [47:0] prod_r;
  logic [38:0] part_r;
  logic [35:0] q_r;
  logic [35:0] a_r;
  logic [35:0] b_r;
  logic        turn_r;
  logic [5:0]  idx_r;
  logic [39:0] m2_r;
  logic [35:0] m3_r;
  logic [1:0]  status_r;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [7:0]  out_mult_r;
  logic [11:0] out_mdiv_r;
  logic [7:0]  out_bdiv_r;
  logic [5:0]  out_nb_r;

  div_req_t          div_req;
  logic [DIV_DW-1:0] div_a;
  logic [DIV_VW-1:0] div_b;
  logic              div_done;
  logic [DIV_DW-1:0] div_quo;
  logic [DIV_VW-1:0] div_rem;

  // Request decode with device overrides.
  logic [5:0]  nb_eff;
  logic [18:0] fs_eff;
  logic [1:0]  nov_sh_eff;
  logic [24:0] nbfs;
  logic [40:0] gen_rate;

  // Step signals.
  logic [41:0] find_sum;
  logic [41:0] find_red;
  logic        found;
  logic        fref_more;
  logic [8:0]  prime;
  logic        tp_hit;
  logic        tp_last;
  logic [10:0] nov;
  logic        range_bad;
  logic        out_free;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_r <= CPU_RESET_HZ;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CPU_CLOCK)) begin
      cpu_r <= pwdata[28:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CPU_CLOCK) ? {3'd0, cpu_r} : 32'd0;

  // Device overrides of word length, sample rate and oversampling.
  always_comb begin
    nb_eff     = in_word_bits;
    fs_eff     = in_sample_rate;
    nov_sh_eff = 2'd0;
    case (in_device_kind)
      KIND_BOARD: begin
        nb_eff = 6'd12;
        fs_eff = 19'd44100;
      end
      KIND_CODEC: begin
        nov_sh_eff = (in_sample_rate > 19'd48000) ? 2'd0 : 2'd1;
      end
      KIND_CONV: begin
        nb_eff = 6'd32;
        if (in_sample_rate <= 19'd48000) begin
          nov_sh_eff = 2'd2;
        end else if (in_sample_rate <= 19'd96000) begin
          nov_sh_eff = 2'd1;
        end else begin
          nov_sh_eff = 2'd0;
        end
      end
      default: begin
        nov_sh_eff = 2'd0;
      end
    endcase
  end

  assign nbfs     = 25'(in_word_bits * in_sample_rate);
  assign gen_rate = {15'd0, nbfs, 1'b0};

  // Multiplier search: running residue of r*m modulo the rate.
  assign find_sum = {1'b0, acc_r} + {1'b0, r_r};
  assign find_red = (find_sum >= {1'b0, rate_r}) ? (find_sum - {1'b0, rate_r}) : find_sum;
  assign found    = (find_red == 42'd0);

  assign fref_more = (div_quo[2:0] != 3'd0) && (fref_r < {1'b0, cpu_r});
  assign prime     = PRIMES[idx_r];
  assign tp_hit    = (div_rem == '0);
  assign tp_last   = (idx_r == 6'(PRIME_COUNT - 1));
  assign nov       = 11'd256 << nov_sh_r;
  assign range_bad = (m2_r == 40'd0) || (m2_r > 40'd4096) ||
                     (m3_r == 36'd0) || (m3_r > 36'd256);
  assign out_free  = !out_valid_r || out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: next state and divider launch.
  always_comb begin
    state_nxt       = state_r;
    div_req.start   = 1'b0;
    div_req.long_op = 1'b0;
    div_a           = '0;
    div_b           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_device_kind != KIND_GENERIC) begin
            state_nxt = (fs_eff == 19'd0) ? ST_DONE : ST_FREF_GO;
          end else begin
            state_nxt = (gen_rate == 41'd0) ? ST_DONE : ST_DIVR_GO;
          end
        end
      end
      ST_FREF_GO: begin
        div_req.start = 1'b1;
        div_a         = DIV_DW'(fref_r);
        div_b         = DIV_VW'(fs_r);
        state_nxt     = ST_FREF_WAIT;
      end
      ST_FREF_WAIT: begin
        if (div_done) begin
          state_nxt = fref_more ? ST_FREF_GO : ST_S0_MUL;
        end
      end
      ST_S0_MUL: begin
        state_nxt = ST_DIVR_GO;
      end
      ST_DIVR_GO: begin
        div_req.start   = 1'b1;
        div_req.long_op = 1'b1;
        div_a           = DIV_DW'(s0_r);
        div_b           = rate_r;
        state_nxt       = ST_DIVR_WAIT;
      end
      ST_DIVR_WAIT: begin
        if (div_done) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        if (found) begin
          state_nxt = (kind_r == KIND_GENERIC) ? ST_GQ_MUL : ST_M2_MUL;
        end else if (m_r == 8'(MULT_LIMIT - 2)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_M2_MUL: begin
        state_nxt = ST_M2_GO;
      end
      ST_M2_GO: begin
        div_req.start   = 1'b1;
        div_req.long_op = 1'b1;
        div_a           = DIV_DW'(prod_r);
        div_b           = rate_r;
        state_nxt       = ST_M2_WAIT;
      end
      ST_M2_WAIT: begin
        if (div_done) begin
          state_nxt = (nb_r == 6'd0) ? ST_CHECK : ST_M3_GO;
        end
      end
      ST_M3_GO: begin
        div_req.start = 1'b1;
        div_a         = DIV_DW'(nov);
        div_b         = DIV_VW'({nb_r, 2'b00});
        state_nxt     = ST_M3_WAIT;
      end
      ST_M3_WAIT: begin
        if (div_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_GQ_MUL: begin
        state_nxt = ST_GQ_GO;
      end
      ST_GQ_GO: begin
        div_req.start = 1'b1;
        div_a         = DIV_DW'(prod_r);
        div_b         = rate_r;
        state_nxt     = ST_GQ_WAIT;
      end
      ST_GQ_WAIT: begin
        if (div_done) begin
          state_nxt = ST_TP_GO;
        end
      end
      ST_TP_GO: begin
        div_req.start = 1'b1;
        div_a         = DIV_DW'(q_r);
        div_b         = DIV_VW'(prime);
        state_nxt     = ST_TP_WAIT;
      end
      ST_TP_WAIT: begin
        if (div_done) begin
          if (tp_hit) begin
            state_nxt = (div_quo <= DIV_DW'(1)) ? ST_TP_FIN : ST_TP_GO;
          end else if (tp_last) begin
            state_nxt = (q_r <= 36'd1) ? ST_TP_FIN : ST_DONE;
          end else begin
            state_nxt = ST_TP_GO;
          end
        end
      end
      ST_TP_FIN: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  // Working registers, updated by the step the sequencer is in.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        kind_r   <= in_device_kind;
        nb_r     <= nb_eff;
        fs_r     <= fs_eff;
        nov_sh_r <= nov_sh_eff;
        fref_r   <= FREF_STEP;
        status_r <= STAT_OK;
        if (in_device_kind != KIND_GENERIC) begin
          if (fs_eff == 19'd0) begin
            status_r <= STAT_NO_MULT;
          end
        end else begin
          rate_r <= gen_rate;
          s0_r   <= 59'(cpu_r >> 1);
          if (gen_rate == 41'd0) begin
            status_r <= STAT_NO_MULT;
          end
        end
      end
      ST_FREF_WAIT: begin
        if (div_done) begin
          scl_r <= div_quo[29:0];
          if (fref_more) begin
            fref_r <= fref_r + FREF_STEP;
          end
        end
      end
      ST_S0_MUL: begin
        s0_r   <= 59'(cpu_r * scl_r);
        rate_r <= {3'd0, fref_r, 8'd0} << nov_sh_r;
      end
      ST_DIVR_WAIT: begin
        if (div_done) begin
          q0_r  <= div_quo[30:0];
          r_r   <= div_rem;
          acc_r <= '0;
          m_r   <= '0;
        end
      end
      ST_FIND: begin
        acc_r <= find_red[40:0];
        m_r   <= m_r + 8'd1;
        m1_r  <= m_r + 8'd1;
        if (!found && (m_r == 8'(MULT_LIMIT - 2))) begin
          status_r <= STAT_NO_MULT;
        end
      end
      ST_M2_MUL: begin
        prod_r <= 48'(r_r * m1_r);
        part_r <= 39'(q0_r * m1_r);
      end
      ST_M2_WAIT: begin
        if (div_done) begin
          m2_r <= 40'(part_r) + 40'(div_quo[39:0]);
          m3_r <= '0;
        end
      end
      ST_M3_WAIT: begin
        if (div_done) begin
          m3_r <= div_quo[35:0];
        end
      end
      ST_GQ_MUL: begin
        prod_r <= 48'(s0_r[27:0] * m1_r);
      end
      ST_GQ_WAIT: begin
        if (div_done) begin
          q_r    <= div_quo[35:0];
          a_r    <= 36'd1;
          b_r    <= 36'd1;
          turn_r <= 1'b0;
          idx_r  <= '0;
        end
      end
      ST_TP_WAIT: begin
        if (div_done) begin
          if (tp_hit) begin
            q_r    <= div_quo[35:0];
            turn_r <= !turn_r;
            idx_r  <= '0;
            if (!turn_r) begin
              a_r <= 36'(a_r * prime);
            end else begin
              b_r <= 36'(b_r * prime);
            end
          end else if (tp_last) begin
            if (q_r > 36'd1) begin
              status_r <= STAT_UNFACT;
            end
          end else begin
            idx_r <= idx_r + 6'd1;
          end
        end
      end
      ST_TP_FIN: begin
        if (a_r > b_r) begin
          m2_r <= 40'(a_r);
          m3_r <= b_r;
        end else begin
          m2_r <= 40'(b_r);
          m3_r <= a_r;
        end
      end
      ST_CHECK: begin
        if (range_bad) begin
          status_r <= STAT_RANGE;
        end
      end
      default: begin
        m_r <= m_r;
      end
    endcase
  end

  // Shared divider.
  acd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Output register; codes read as zero unless the solve succeeded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_status_r <= status_r;
      out_nb_r     <= nb_r;
      if (status_r == STAT_OK) begin
        out_mult_r <= m1_r - 8'd1;
        out_mdiv_r <= m2_r[11:0] - 12'd1;
        out_bdiv_r <= m3_r[7:0] - 8'd1;
      end else begin
        out_mult_r <= '0;
        out_mdiv_r <= '0;
        out_bdiv_r <= '0;
      end
    end
  end

  assign out_valid                  = out_valid_r;
  assign out_status                 = out_status_r;
  assign out_mclk_multiplier_code   = out_mult_r;
  assign out_mclk_divider_code      = out_mdiv_r;
  assign out_bit_clock_divider_code = out_bdiv_r;
  assign out_word_bits_used         = out_nb_r;

  a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second item taken mid-solve");

  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |->
      ((out_mclk_multiplier_code == 8'd0) && (out_mclk_divider_code == 12'd0) &&
       (out_bit_clock_divider_code == 8'd0)))
    else $error("failed item carries nonzero codes");

  a_find_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND) |-> (m_r <= 8'(MULT_LIMIT - 2)))
    else $error("multiplier search ran past its limit");

  a_div_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == ST_FREF_WAIT) || (state_r == ST_DIVR_WAIT) ||
                  (state_r == ST_M2_WAIT) || (state_r == ST_M3_WAIT) ||
                  (state_r == ST_GQ_WAIT) || (state_r == ST_TP_WAIT)))
    else $error("divider finished outside a wait step");

endmodule

### rtl/acd_div.sv
module acd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acd_pkg::div_req_t             req,
  input  logic [acd_pkg::DIV_DW-1:0]    dividend,
  input  logic [acd_pkg::DIV_VW-1:0]    divisor,
  output logic                          done,
  output logic [acd_pkg::DIV_DW-1:0]    quo,
  output logic [acd_pkg::DIV_VW-1:0]    rem
);
  import acd_pkg::*;

  logic [DIV_DW-1:0] d_r;
  logic [DIV_VW-1:0] rem_r;
  logic [DIV_VW-1:0] dvs_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_VW:0]   sh;
  logic [DIV_VW:0]   diff;
  logic              fit;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign sh   = {rem_r, d_r[DIV_DW-1]};
  assign diff = sh - {1'b0, dvs_r};
  assign fit  = (sh >= {1'b0, dvs_r});

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.long_op ? 6'(DIV_DW) : 6'(DIV_SHORT);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Quotient bits shift in at the bottom as the dividend shifts out the top.
  always_ff @(posedge clk) begin
    if (req.start) begin
      d_r   <= req.long_op ? dividend : (dividend << (DIV_DW - DIV_SHORT));
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      d_r   <= {d_r[DIV_DW-2:0], fit};
      rem_r <= fit ? diff[DIV_VW-1:0] : sh[DIV_VW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = d_r;
  assign rem  = rem_r;

  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");

  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");

endmodule
